// ===== rtl/sbi_pkg.sv =====
`default_nettype none
package sbi_pkg;

   localparam int LANES       = 8;
   localparam int VALUE_BITS  = 16;
   localparam int WORD_BITS   = 64;
   localparam int BLOCK_BITS  = 2 * WORD_BITS;
   localparam int PREFIX_BITS = 16;
   localparam int RESULT_BITS = 32;
   localparam int LANE_IDX_W  = (LANES > 1) ? $clog2(LANES) : 1;

   typedef logic [VALUE_BITS-1:0]             lane_type;
   typedef logic [LANES-1:0][VALUE_BITS-1:0]  lanes_type;

   typedef struct packed {
      logic [LANES-1:0] hit;
      logic             adv_a;
      logic             adv_b;
   } match_info_type;

   function automatic lane_type lane_of(input logic [BLOCK_BITS-1:0] block, input int idx);
      logic [BLOCK_BITS-1:0] shifted;
      shifted = block >> (idx * VALUE_BITS);
      return shifted[VALUE_BITS-1:0];
   endfunction

   function automatic logic [RESULT_BITS-1:0] make_value(input logic [PREFIX_BITS-1:0] pre,
                                                         input lane_type lane);
      logic [PREFIX_BITS+VALUE_BITS-1:0] wide;
      wide = ({{VALUE_BITS{1'b0}}, pre} << VALUE_BITS)
           | {{PREFIX_BITS{1'b0}}, lane};
      if (PREFIX_BITS + VALUE_BITS >= RESULT_BITS) begin
         return wide[RESULT_BITS-1:0];
      end else begin
         return RESULT_BITS'(wide);
      end
   endfunction

endpackage
`default_nettype wire

// ===== rtl/sbi_req_if.sv =====
`default_nettype none
interface sbi_req_if;
   logic                              valid;
   logic                              ready;
   logic [sbi_pkg::WORD_BITS-1:0]     a_words_low;
   logic [sbi_pkg::WORD_BITS-1:0]     a_words_high;
   logic [sbi_pkg::WORD_BITS-1:0]     b_words_low;
   logic [sbi_pkg::WORD_BITS-1:0]     b_words_high;
   logic [sbi_pkg::PREFIX_BITS-1:0]   prefix;

   modport source (output valid, output a_words_low, output a_words_high,
                   output b_words_low, output b_words_high, output prefix,
                   input ready);
   modport sink (input valid, input a_words_low, input a_words_high,
                 input b_words_low, input b_words_high, input prefix,
                 output ready);
endinterface
`default_nettype wire

// ===== rtl/sbi_rsp_if.sv =====
`default_nettype none
interface sbi_rsp_if;
   logic                              valid;
   logic                              ready;
   logic                              match_valid;
   logic [sbi_pkg::RESULT_BITS-1:0]   match_value;
   logic                              last;
   logic                              advance_a;
   logic                              advance_b;

   modport source (output valid, output match_valid, output match_value,
                   output last, output advance_a, output advance_b,
                   input ready);
   modport sink (input valid, input match_valid, input match_value,
                 input last, input advance_a, input advance_b,
                 output ready);
endinterface
`default_nettype wire

// ===== rtl/sbi_match.sv =====
`default_nettype none
module sbi_match (
   input  wire logic [sbi_pkg::WORD_BITS-1:0] a_words_low,
   input  wire logic [sbi_pkg::WORD_BITS-1:0] a_words_high,
   input  wire logic [sbi_pkg::WORD_BITS-1:0] b_words_low,
   input  wire logic [sbi_pkg::WORD_BITS-1:0] b_words_high,
   output sbi_pkg::lanes_type                 a_lanes,
   output sbi_pkg::match_info_type            info
);

   sbi_pkg::lanes_type b_lanes;

   always_comb begin
      for (int i = 0; i < sbi_pkg::LANES; i++) begin
         a_lanes[i] = sbi_pkg::lane_of({a_words_high, a_words_low}, i);
         b_lanes[i] = sbi_pkg::lane_of({b_words_high, b_words_low}, i);
      end
   end

   always_comb begin
      info.hit = '0;
      for (int i = 0; i < sbi_pkg::LANES; i++) begin
         for (int j = 0; j < sbi_pkg::LANES; j++) begin
            if (a_lanes[i] == b_lanes[j]) begin
               info.hit[i] = 1'b1;
            end
         end
      end
      info.adv_a = (a_lanes[sbi_pkg::LANES-1] <= b_lanes[sbi_pkg::LANES-1]);
      info.adv_b = (b_lanes[sbi_pkg::LANES-1] <= a_lanes[sbi_pkg::LANES-1]);
   end

endmodule
`default_nettype wire

// ===== rtl/sbi_emit.sv =====
`default_nettype none
module sbi_emit (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            in_valid,
   output logic                                 in_ready,
   input  wire sbi_pkg::lanes_type              in_lanes,
   input  wire sbi_pkg::match_info_type         in_info,
   input  wire logic [sbi_pkg::PREFIX_BITS-1:0] in_prefix,
   output logic                                 out_valid,
   input  wire logic                            out_ready,
   output logic                                 out_match_valid,
   output logic [sbi_pkg::RESULT_BITS-1:0]      out_match_value,
   output logic                                 out_last,
   output logic                                 out_advance_a,
   output logic                                 out_advance_b
);

   logic                              work_valid_ff, work_valid_in;
   sbi_pkg::lanes_type                lanes_ff, lanes_in;
   sbi_pkg::match_info_type           info_ff, info_in;
   logic [sbi_pkg::PREFIX_BITS-1:0]   prefix_ff, prefix_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              match_valid_ff, match_valid_in;
   logic [sbi_pkg::RESULT_BITS-1:0]   match_value_ff, match_value_in;
   logic                              last_ff, last_in;
   logic                              adv_a_ff, adv_a_in;
   logic                              adv_b_ff, adv_b_in;

   logic                              out_free;
   logic                              fire;
   logic                              done;
   logic                              accept;
   logic [sbi_pkg::LANE_IDX_W-1:0]    sel;
   logic [sbi_pkg::LANES-1:0]         rest;

   always_comb begin
      sel = '0;
      for (int i = sbi_pkg::LANES - 1; i >= 0; i--) begin
         if (info_ff.hit[i]) begin
            sel = sbi_pkg::LANE_IDX_W'(i);
         end
      end
      rest = info_ff.hit & (info_ff.hit - 1'b1);
   end

   assign out_free = !rsp_valid_ff || out_ready;
   assign fire     = work_valid_ff && out_free;
   assign done     = fire && (rest == '0);
   assign in_ready = !work_valid_ff || done;
   assign accept   = in_valid && in_ready;

   always_comb begin
      work_valid_in  = work_valid_ff;
      lanes_in       = lanes_ff;
      info_in        = info_ff;
      prefix_in      = prefix_ff;
      rsp_valid_in   = rsp_valid_ff;
      match_valid_in = match_valid_ff;
      match_value_in = match_value_ff;
      last_in        = last_ff;
      adv_a_in       = adv_a_ff;
      adv_b_in       = adv_b_ff;

      if (out_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (fire) begin
         rsp_valid_in   = 1'b1;
         match_valid_in = (info_ff.hit != '0);
         match_value_in = (info_ff.hit != '0)
                        ? sbi_pkg::make_value(prefix_ff, lanes_ff[sel]) : '0;
         last_in        = (rest == '0);
         adv_a_in       = info_ff.adv_a;
         adv_b_in       = info_ff.adv_b;
         info_in.hit    = rest;
      end
      if (done) begin
         work_valid_in = 1'b0;
      end
      if (accept) begin
         work_valid_in = 1'b1;
         lanes_in      = in_lanes;
         info_in       = in_info;
         prefix_in     = in_prefix;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         work_valid_ff <= work_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      lanes_ff       <= lanes_in;
      info_ff        <= info_in;
      prefix_ff      <= prefix_in;
      match_valid_ff <= match_valid_in;
      match_value_ff <= match_value_in;
      last_ff        <= last_in;
      adv_a_ff       <= adv_a_in;
      adv_b_ff       <= adv_b_in;
   end

   assign out_valid       = rsp_valid_ff;
   assign out_match_valid = match_valid_ff;
   assign out_match_value = match_value_ff;
   assign out_last        = last_ff;
   assign out_advance_a   = adv_a_ff;
   assign out_advance_b   = adv_b_ff;

endmodule
`default_nettype wire

// ===== rtl/sorted_block_intersect_8x16_unit.sv =====
// An accepted block is held in the work register; each result is then registered for output.
// Throughput: a block yields max(1, matches) results, at most eight, through the single result
// register that moves one compacted match per cycle unless the output stalls; a new block is
// taken in the cycle its final result is loaded.
// Reset: synchronous, active high; clears the work and result valid flags only.
`default_nettype none
module sorted_block_intersect_8x16_unit (
   input  wire logic clock,
   input  wire logic reset,
   sbi_req_if.sink   req_chan,
   sbi_rsp_if.source rsp_chan
);

   sbi_pkg::lanes_type      a_lanes;
   sbi_pkg::match_info_type info;

   sbi_match u_match (
      .a_words_low  (req_chan.a_words_low),
      .a_words_high (req_chan.a_words_high),
      .b_words_low  (req_chan.b_words_low),
      .b_words_high (req_chan.b_words_high),
      .a_lanes      (a_lanes),
      .info         (info)
   );

   sbi_emit u_emit (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (req_chan.valid),
      .in_ready        (req_chan.ready),
      .in_lanes        (a_lanes),
      .in_info         (info),
      .in_prefix       (req_chan.prefix),
      .out_valid       (rsp_chan.valid),
      .out_ready       (rsp_chan.ready),
      .out_match_valid (rsp_chan.match_valid),
      .out_match_value (rsp_chan.match_value),
      .out_last        (rsp_chan.last),
      .out_advance_a   (rsp_chan.advance_a),
      .out_advance_b   (rsp_chan.advance_b)
   );

endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

typedef struct packed {
   logic                            match_valid;
   logic [sbi_pkg::RESULT_BITS-1:0] match_value;
   logic                            last;
   logic                            advance_a;
   logic                            advance_b;
} match_result_type;

class intersect_scoreboard;
   match_result_type expected_matches[$];
   int unsigned      errors = 0;

   function void note_block(input sbi_pkg::lanes_type a_lanes,
                            input sbi_pkg::lanes_type b_lanes,
                            input logic [sbi_pkg::PREFIX_BITS-1:0] pre);
      logic [sbi_pkg::LANES-1:0] hit_mask;
      int                        hit_count;
      int                        emitted;
      logic                      adv_a;
      logic                      adv_b;
      match_result_type          entry;
      adv_a = (a_lanes[sbi_pkg::LANES-1] <= b_lanes[sbi_pkg::LANES-1]);
      adv_b = (b_lanes[sbi_pkg::LANES-1] <= a_lanes[sbi_pkg::LANES-1]);
      hit_mask = '0;
      hit_count = 0;
      for (int i = 0; i < sbi_pkg::LANES; i++) begin
         for (int j = 0; j < sbi_pkg::LANES; j++) begin
            if (a_lanes[i] == b_lanes[j]) hit_mask[i] = 1'b1;
         end
         if (hit_mask[i]) hit_count++;
      end
      entry.advance_a = adv_a;
      entry.advance_b = adv_b;
      if (hit_count == 0) begin
         entry.match_valid = 1'b0;
         entry.match_value = '0;
         entry.last        = 1'b1;
         expected_matches.push_back(entry);
      end else begin
         emitted = 0;
         for (int i = 0; i < sbi_pkg::LANES; i++) begin
            if (hit_mask[i]) begin
               emitted++;
               entry.match_valid = 1'b1;
               entry.match_value = {pre, a_lanes[i]};
               entry.last        = (emitted == hit_count);
               expected_matches.push_back(entry);
            end
         end
      end
   endfunction

   function void check_result(input match_result_type got);
      match_result_type want;
      if (expected_matches.size() == 0) begin
         $error("unexpected result: match_value %h", got.match_value);
         errors++;
         return;
      end
      want = expected_matches.pop_front();
      if (got.match_valid !== want.match_valid) begin
         $error("match_valid: expected %0d, actual %0d", want.match_valid, got.match_valid);
         errors++;
      end
      if (got.match_value !== want.match_value) begin
         $error("match_value: expected %h, actual %h", want.match_value, got.match_value);
         errors++;
      end
      if (got.last !== want.last) begin
         $error("last: expected %0d, actual %0d", want.last, got.last);
         errors++;
      end
      if (got.advance_a !== want.advance_a) begin
         $error("advance_a: expected %0d, actual %0d", want.advance_a, got.advance_a);
         errors++;
      end
      if (got.advance_b !== want.advance_b) begin
         $error("advance_b: expected %0d, actual %0d", want.advance_b, got.advance_b);
         errors++;
      end
   endfunction

   function int unsigned outstanding();
      return expected_matches.size();
   endfunction
endclass

module testbench;
   localparam int HALF        = sbi_pkg::LANES / 2;
   localparam int CYCLE_LIMIT = 500000;

   logic clock;
   logic reset;

   sbi_req_if req_bus ();
   sbi_rsp_if rsp_bus ();

   sorted_block_intersect_8x16_unit uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   intersect_scoreboard sb;
   int                  send_idle_pct = 0;
   int                  stall_pct = 0;
   int                  stall_left = 0;
   int                  cycle_count = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int pick_gap(input int pct);
      if ($urandom_range(0, 99) >= pct) return 0;
      if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic sbi_pkg::lanes_type ramp(input sbi_pkg::lane_type start,
                                               input int step);
      sbi_pkg::lanes_type lanes;
      for (int i = 0; i < sbi_pkg::LANES; i++) begin
         lanes[i] = sbi_pkg::lane_type'(int'(start) + i * step);
      end
      return lanes;
   endfunction

   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_bus.ready <= 1'b1;
         stall_left <= pick_gap(stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         sb.check_result(match_result_type'{rsp_bus.match_valid, rsp_bus.match_value,
                                            rsp_bus.last, rsp_bus.advance_a,
                                            rsp_bus.advance_b});
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic send_block(input sbi_pkg::lanes_type a_lanes,
                             input sbi_pkg::lanes_type b_lanes,
                             input logic [sbi_pkg::PREFIX_BITS-1:0] pre);
      int gap;
      req_bus.valid        <= 1'b1;
      req_bus.a_words_low  <= a_lanes[HALF-1:0];
      req_bus.a_words_high <= a_lanes[sbi_pkg::LANES-1:HALF];
      req_bus.b_words_low  <= b_lanes[HALF-1:0];
      req_bus.b_words_high <= b_lanes[sbi_pkg::LANES-1:HALF];
      req_bus.prefix       <= pre;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sb.note_block(a_lanes, b_lanes, pre);
      gap = pick_gap(send_idle_pct);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      req_bus.valid <= 1'b0;
      while (sb.outstanding() != 0) @(posedge clock);
   endtask

   task automatic random_block();
      sbi_pkg::lanes_type a_lanes;
      sbi_pkg::lanes_type b_lanes;
      int                 mode;
      int                 offset;
      mode = $urandom_range(0, 99);
      if (mode < 70) begin
         // sorted runs that overlap by a random amount
         a_lanes[0] = sbi_pkg::lane_type'($urandom_range(0, 65535));
         offset = $urandom_range(0, 8);
         if ($urandom_range(0, 1) == 1) begin
            b_lanes[0] = sbi_pkg::lane_type'(int'(a_lanes[0]) + offset);
         end else begin
            b_lanes[0] = sbi_pkg::lane_type'(int'(a_lanes[0]) - offset);
         end
         for (int i = 1; i < sbi_pkg::LANES; i++) begin
            a_lanes[i] = sbi_pkg::lane_type'(int'(a_lanes[i-1]) + $urandom_range(0, 3));
            b_lanes[i] = sbi_pkg::lane_type'(int'(b_lanes[i-1]) + $urandom_range(0, 3));
         end
      end else if (mode < 85) begin
         for (int i = 0; i < sbi_pkg::LANES; i++) begin
            a_lanes[i] = sbi_pkg::lane_type'($urandom_range(0, 15));
            b_lanes[i] = sbi_pkg::lane_type'($urandom_range(0, 15));
         end
      end else begin
         for (int i = 0; i < sbi_pkg::LANES; i++) begin
            a_lanes[i] = sbi_pkg::lane_type'($urandom_range(0, 65535));
            b_lanes[i] = sbi_pkg::lane_type'($urandom_range(0, 65535));
         end
      end
      send_block(a_lanes, b_lanes, sbi_pkg::PREFIX_BITS'($urandom_range(0, 65535)));
   endtask

   initial begin
      sb = new();
      clock                = 1'b0;
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.a_words_low  = '0;
      req_bus.a_words_high = '0;
      req_bus.b_words_low  = '0;
      req_bus.b_words_high = '0;
      req_bus.prefix       = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 20;
      stall_pct     = 20;
      send_block(ramp(16'h0000, 0), ramp(16'h0000, 0), 16'h0000);
      send_block(ramp(16'hFFFF, 0), ramp(16'hFFFF, 0), 16'hFFFF);
      send_block(ramp(16'h0000, 0), ramp(16'hFFFF, 0), 16'hFFFF);
      send_block(ramp(16'hFFFF, 0), ramp(16'h0000, 0), 16'h0000);
      send_block(ramp(16'd100, 3), ramp(16'd100, 3), 16'h1234);
      send_block(ramp(16'd0, 2), ramp(16'd1, 2), 16'h00FF);
      send_block(ramp(16'd1, 2), ramp(16'd0, 2), 16'hFF00);
      send_block(ramp(16'd50, 1), ramp(16'd43, 1), 16'h8001);
      send_block(ramp(16'd43, 1), ramp(16'd50, 1), 16'h7FFE);
      send_block(ramp(16'd7, 0), ramp(16'd0, 1), 16'h0001);
      send_block(ramp(16'hFFFC, 1), ramp(16'd0, 1), 16'h8000);
      send_block(ramp(16'h5555, 0), ramp(16'hAAAA, 0), 16'h5555);
      send_block(ramp(16'hAAAA, 0), ramp(16'h5555, 0), 16'hAAAA);
      send_block(ramp(16'h8000, 0), ramp(16'h7FF9, 1), 16'h4321);
      send_block(ramp(16'd0, 2), ramp(16'd0, 4), 16'hBEEF);
      send_block(ramp(16'd0, 4), ramp(16'd0, 2), 16'h0F0F);
      send_block(ramp(16'hFFF0, 2), ramp(16'hFFF0, 2), 16'hF0F0);
      send_block(ramp(16'd20, -1), ramp(16'd13, 1), 16'h2468);
      drain_results();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 0;
               stall_pct     = 0;
            end
            1: begin
               send_idle_pct = 30;
               stall_pct     = 25;
            end
            2: begin
               send_idle_pct = 10;
               stall_pct     = 60;
            end
            default: begin
               send_idle_pct = 50;
               stall_pct     = 10;
            end
         endcase
         repeat (88) random_block();
         drain_results();
      end

      repeat (16) @(posedge clock);
      if (sb.errors == 0 && sb.outstanding() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
